// ----- hdl/qenc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qenc_pkg;

   // Position counter width and derived limits.
   localparam int POSITION_BITS = 8;
   localparam int POS_LIMIT     = (1 << (POSITION_BITS - 1)) - 1;
   localparam int STEP_COUNTS   = 4;
   localparam int MAX_RESULTS   = 31;
   localparam int COUNT_BITS    = $clog2(MAX_RESULTS + 1);

   // Operand of the shared adder: table moves -2..+2 and the step of 4.
   localparam int OPER_BITS = 4;

   // APB register file.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_RIGHT_ENABLE     = 3'd0;
   localparam logic [2:0] REG_LEFT_ENABLE      = 3'd1;
   localparam logic [2:0] REG_RIGHT_ALT_ENABLE = 3'd2;
   localparam logic [2:0] REG_LEFT_ALT_ENABLE  = 3'd3;
   localparam logic [2:0] REG_CLICK_ENABLE     = 3'd4;
   localparam logic [2:0] REG_INITIAL_PHASE    = 3'd5;

   // Event codes.
   localparam logic [2:0] EV_RIGHT     = 3'd0;
   localparam logic [2:0] EV_LEFT      = 3'd1;
   localparam logic [2:0] EV_RIGHT_ALT = 3'd2;
   localparam logic [2:0] EV_LEFT_ALT  = 3'd3;
   localparam logic [2:0] EV_CLICK     = 3'd4;

   // Button tracking codes.
   localparam logic [1:0] BTN_NONE  = 2'd0;
   localparam logic [1:0] BTN_CLICK = 2'd1;
   localparam logic [1:0] BTN_SHIFT = 2'd2;

   typedef logic signed [POSITION_BITS-1:0] position_type;
   typedef logic signed [OPER_BITS-1:0]     operand_type;

   // Configuration as seen by the decoder.
   typedef struct packed {
      logic       right_enable;
      logic       left_enable;
      logic       right_alt_enable;
      logic       left_alt_enable;
      logic       click_enable;
      logic [1:0] initial_phase;
      logic       phase_load;
   } cfg_type;

   // Status flags of the adder result.
   typedef struct packed {
      logic above_zero;
      logic below_zero;
      logic at_least_step;
      logic at_most_neg_step;
   } alu_flags_type;

   // Quarter-step movement indexed by {new_b, new_a, old_phase}.
   function automatic operand_type move_step(input logic [3:0] idx);
      operand_type mv;
      case (idx)
         4'd0:    mv = 4'sd0;
         4'd1:    mv = 4'sd1;
         4'd2:    mv = -4'sd1;
         4'd3:    mv = 4'sd2;
         4'd4:    mv = -4'sd1;
         4'd5:    mv = 4'sd0;
         4'd6:    mv = -4'sd2;
         4'd7:    mv = 4'sd1;
         4'd8:    mv = 4'sd1;
         4'd9:    mv = -4'sd2;
         4'd10:   mv = 4'sd0;
         4'd11:   mv = -4'sd1;
         4'd12:   mv = 4'sd2;
         4'd13:   mv = -4'sd1;
         4'd14:   mv = 4'sd1;
         default: mv = 4'sd0;
      endcase
      return mv;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/qenc_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one pin or button change per item.
interface qenc_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic phase_a;
   logic phase_b;
   logic button_level;

   modport source (output valid, output mode, output phase_a, output phase_b,
                   output button_level, input ready);
   modport sink   (input valid, input mode, input phase_a, input phase_b,
                   input button_level, output ready);
endinterface

// Result channel: one event per item.
interface qenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic       is_last;

   modport source (output valid, output event_kind, output is_last, input ready);
   modport sink   (input valid, input event_kind, input is_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/qenc_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qenc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [qenc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [qenc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [qenc_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                      pready,
   output qenc_pkg::cfg_type                         cfg
);
   import qenc_pkg::*;

   logic       right_en_ff, right_en_in;
   logic       left_en_ff, left_en_in;
   logic       right_alt_en_ff, right_alt_en_in;
   logic       left_alt_en_ff, left_alt_en_in;
   logic       click_en_ff, click_en_in;
   logic [1:0] init_phase_ff, init_phase_in;
   logic       wr_strobe;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;
   assign reg_index = paddr[4:2];

   always_comb begin
      right_en_in     = right_en_ff;
      left_en_in      = left_en_ff;
      right_alt_en_in = right_alt_en_ff;
      left_alt_en_in  = left_alt_en_ff;
      click_en_in     = click_en_ff;
      init_phase_in   = init_phase_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_RIGHT_ENABLE:     right_en_in     = pwdata[0];
            REG_LEFT_ENABLE:      left_en_in      = pwdata[0];
            REG_RIGHT_ALT_ENABLE: right_alt_en_in = pwdata[0];
            REG_LEFT_ALT_ENABLE:  left_alt_en_in  = pwdata[0];
            REG_CLICK_ENABLE:     click_en_in     = pwdata[0];
            REG_INITIAL_PHASE:    init_phase_in   = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_en_ff     <= 1'b1;
         left_en_ff      <= 1'b1;
         right_alt_en_ff <= 1'b0;
         left_alt_en_ff  <= 1'b0;
         click_en_ff     <= 1'b0;
         init_phase_ff   <= 2'd0;
      end else begin
         right_en_ff     <= right_en_in;
         left_en_ff      <= left_en_in;
         right_alt_en_ff <= right_alt_en_in;
         left_alt_en_ff  <= left_alt_en_in;
         click_en_ff     <= click_en_in;
         init_phase_ff   <= init_phase_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         REG_RIGHT_ENABLE:     prdata[0]   = right_en_ff;
         REG_LEFT_ENABLE:      prdata[0]   = left_en_ff;
         REG_RIGHT_ALT_ENABLE: prdata[0]   = right_alt_en_ff;
         REG_LEFT_ALT_ENABLE:  prdata[0]   = left_alt_en_ff;
         REG_CLICK_ENABLE:     prdata[0]   = click_en_ff;
         REG_INITIAL_PHASE:    prdata[1:0] = init_phase_ff;
         default: ;
      endcase
   end

   // A write of the start phase also loads the decoder's phase register.
   assign cfg.right_enable     = right_en_ff;
   assign cfg.left_enable      = left_en_ff;
   assign cfg.right_alt_enable = right_alt_en_ff;
   assign cfg.left_alt_enable  = left_alt_en_ff;
   assign cfg.click_enable     = click_en_ff;
   assign cfg.initial_phase    = pwdata[1:0];
   assign cfg.phase_load       = wr_strobe && (reg_index == REG_INITIAL_PHASE);

endmodule

`default_nettype wire

// ----- hdl/qenc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qenc_alu (
   input  wire qenc_pkg::position_type  position,
   input  wire qenc_pkg::operand_type   operand,
   output qenc_pkg::position_type       result,
   output qenc_pkg::alu_flags_type      flags
);
   import qenc_pkg::*;

   localparam logic signed [POSITION_BITS:0] LIM_POS  = (POSITION_BITS+1)'(POS_LIMIT);
   localparam logic signed [POSITION_BITS:0] LIM_NEG  = -LIM_POS;
   localparam logic signed [POSITION_BITS:0] STEP_POS = (POSITION_BITS+1)'(STEP_COUNTS);
   localparam logic signed [POSITION_BITS:0] STEP_NEG = -STEP_POS;

   logic signed [POSITION_BITS:0] sum;
   logic signed [POSITION_BITS:0] sat;

   // One guard bit keeps the sum exact before clamping to the symmetric limit.
   always_comb begin
      sum = {position[POSITION_BITS-1], position}
          + {{(POSITION_BITS + 1 - OPER_BITS){operand[OPER_BITS-1]}}, operand};
      if (sum > LIM_POS) begin
         sat = LIM_POS;
      end else if (sum < LIM_NEG) begin
         sat = LIM_NEG;
      end else begin
         sat = sum;
      end
   end

   assign result                 = sat[POSITION_BITS-1:0];
   assign flags.above_zero       = (sat > 0);
   assign flags.below_zero       = (sat < 0);
   assign flags.at_least_step    = (sat >= STEP_POS);
   assign flags.at_most_neg_step = (sat <= STEP_NEG);

endmodule

`default_nettype wire

// ----- hdl/qenc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qenc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   qenc_req_if.sink                      req,
   qenc_rsp_if.source                    rsp,
   input  wire qenc_pkg::cfg_type        cfg,
   output qenc_pkg::position_type        alu_position,
   output qenc_pkg::operand_type         alu_operand,
   input  wire qenc_pkg::position_type   alu_result,
   input  wire qenc_pkg::alu_flags_type  alu_flags
);
   import qenc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MOVE = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   localparam operand_type STEP_UP   = OPER_BITS'(STEP_COUNTS);
   localparam operand_type STEP_DOWN = -STEP_UP;

   state_type             state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   position_type          position_ff, position_in;
   logic [1:0]            button_ff, button_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  mode_ff, a_ff, b_ff, btn_ff;
   logic                  click_ff, click_in;
   logic                  down_ff, down_in;
   logic [2:0]            kind_ff, kind_in;
   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            out_kind_ff, out_kind_in;
   logic                  out_last_ff, out_last_in;
   logic                  accept;
   logic                  out_free;
   logic                  have;
   logic                  more;
   logic [3:0]            move_idx;

   assign accept   = req.valid && req.ready;
   assign out_free = !out_valid_ff || rsp.ready;
   assign move_idx = {b_ff, a_ff, phase_ff};
   assign more     = alu_flags.at_least_step || alu_flags.at_most_neg_step;

   // The adder either applies the table move or takes one step off per event.
   assign alu_position = position_ff;
   always_comb begin
      if (state_ff == S_EMIT) begin
         alu_operand = down_ff ? STEP_DOWN : STEP_UP;
      end else begin
         alu_operand = move_step(move_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req.mode;
         a_ff    <= req.phase_a;
         b_ff    <= req.phase_b;
         btn_ff  <= req.button_level;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      position_in  = position_ff;
      button_in    = button_ff;
      count_in     = count_ff;
      click_in     = click_ff;
      down_in      = down_ff;
      kind_in      = kind_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      have         = 1'b0;

      if (cfg.phase_load) begin
         phase_in = cfg.initial_phase;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            count_in = '0;
            if (mode_ff) begin
               // Button change: a release of an untouched press is a click.
               if (btn_ff) begin
                  button_in = BTN_CLICK;
                  state_in  = S_IDLE;
               end else begin
                  button_in = BTN_NONE;
                  click_in  = 1'b1;
                  kind_in   = EV_CLICK;
                  state_in  = (button_ff == BTN_CLICK && cfg.click_enable) ? S_EMIT : S_IDLE;
               end
            end else begin
               phase_in    = {b_ff, a_ff};
               position_in = alu_result;
               click_in    = 1'b0;
               down_in     = alu_flags.above_zero;
               if (button_ff == BTN_NONE) begin
                  if (alu_flags.above_zero && cfg.right_enable) begin
                     have    = 1'b1;
                     kind_in = EV_RIGHT;
                  end else if (alu_flags.below_zero && cfg.left_enable) begin
                     have    = 1'b1;
                     kind_in = EV_LEFT;
                  end
               end else begin
                  if (alu_flags.above_zero && cfg.right_alt_enable) begin
                     have    = 1'b1;
                     kind_in = EV_RIGHT_ALT;
                  end else if (alu_flags.below_zero && cfg.left_alt_enable) begin
                     have    = 1'b1;
                     kind_in = EV_LEFT_ALT;
                  end
                  button_in = BTN_SHIFT;
               end
               state_in = (have && more) ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               if (click_ff) begin
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  // The remainder beyond the event cap stays in the position.
                  position_in = alu_result;
                  count_in    = count_ff + 1'b1;
                  out_last_in = !more || (count_ff == COUNT_BITS'(MAX_RESULTS - 1));
                  state_in    = out_last_in ? S_IDLE : S_EMIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 2'd0;
         position_ff  <= '0;
         button_ff    <= BTN_NONE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         button_ff    <= button_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      click_ff    <= click_in;
      down_ff     <= down_in;
      kind_ff     <= kind_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = out_valid_ff;
   assign rsp.event_kind = out_kind_ff;
   assign rsp.is_last    = out_last_ff;

   // The position never reaches the most negative code.
   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      position_ff != {1'b1, {(POSITION_BITS - 1){1'b0}}})
      else $error("position outside the symmetric limit");

   // The event counter stays below the cap while events are issued.
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (count_ff < COUNT_BITS'(MAX_RESULTS)))
      else $error("event count beyond cap");

   // The button tracker never holds the unused code.
   a_button_code : assert property (@(posedge clock) disable iff (reset)
      button_ff != 2'd3)
      else $error("button tracker holds unused code");

   // A click is only issued for a button item.
   a_click_src : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && click_ff) |-> mode_ff)
      else $error("click issued for a pin item");

   // A new item is never taken while an event is still being issued.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !out_free) |=> (state_ff == S_EMIT))
      else $error("emission abandoned while output was busy");

endmodule

`default_nettype wire

// ----- hdl/quadrature_encoder_with_button_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Content
// req_chan  in         valid/ready          mode, phase_a, phase_b, button_level
// rsp_chan  out        valid/ready          event_kind, is_last
// APB       in/out     psel/penable/pready  six control registers at 4*index
//
// An item is taken only while the sequencer is idle. It is first captured,
// then the table move or button change is applied through the shared adder,
// and then its events are issued in turn. Each turn event passes through the
// one shared adder, which takes one step of four off the position per cycle
// while the result channel is not stalled. A stalled result channel holds the
// sequencer in its event state; the final event of an item may wait in the
// output register while the next item is accepted. Reset is synchronous,
// clears the sequencer, position, phase and button tracking, and needs no
// clearing pass.

module quadrature_encoder_with_button_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   qenc_req_if.sink                                  req_chan,
   qenc_rsp_if.source                                rsp_chan,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [qenc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [qenc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [qenc_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                      pready
);
   import qenc_pkg::*;

   cfg_type       cfg;
   position_type  alu_position;
   operand_type   alu_operand;
   position_type  alu_result;
   alu_flags_type alu_flags;

   // Register file; writing the start phase also reloads the decoder phase.
   qenc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Shared saturating adder with sign and step compares on its result.
   qenc_alu u_alu (
      .position (alu_position),
      .operand  (alu_operand),
      .result   (alu_result),
      .flags    (alu_flags)
   );

   // Sequencer that owns the decoder state and the output register.
   qenc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .cfg          (cfg),
      .alu_position (alu_position),
      .alu_operand  (alu_operand),
      .alu_result   (alu_result),
      .alu_flags    (alu_flags)
   );

endmodule

`default_nettype wire

// ----- test/tb_quadrature_encoder_with_button_unit.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the rotary encoder decoder. A queue of pin and button
// changes feeds a driver on the falling edge; one monitor on the rising edge
// predicts the events of every accepted item and checks the event stream.
module tb_quadrature_encoder_with_button_unit;
   import qenc_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   // An item that emits nothing leaves the sequencer straight from its move state
   // after it is taken, so waiting this long before a register write leaves ample margin.
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AT_FIRST = 30;
   localparam int HOLD_AT_LATER = 395;

   // Quarter-step move for the index {new B, new A, old phase}.
   localparam int QUARTER_MOVE [16] = '{0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0};
   // Next phase for one step that moves the position up or down by one.
   localparam logic [1:0] PHASE_UP   [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] PHASE_DOWN [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   typedef struct packed {
      logic mode;
      logic phase_a;
      logic phase_b;
      logic button_level;
   } enc_change_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       last;
   } enc_event_type;

   logic clock = 1'b0;
   logic reset;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   qenc_req_if req_chan ();
   qenc_rsp_if rsp_chan ();

   quadrature_encoder_with_button_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   // Changes waiting to be offered, and events the decoder still owes us.
   enc_change_type pending_changes [$];
   enc_event_type  expected_events [$];

   int offered_changes  = 0;
   int accepted_changes = 0;
   int mismatches       = 0;
   int cycle_count      = 0;

   // Our own copy of the decoder: settings as written and the running state.
   logic       cfg_right_en     = 1'b1;
   logic       cfg_left_en      = 1'b1;
   logic       cfg_right_alt_en = 1'b0;
   logic       cfg_left_alt_en  = 1'b0;
   logic       cfg_click_en     = 1'b0;
   logic [1:0] pred_phase       = 2'd0;
   int         pred_position    = 0;
   logic [1:0] pred_button      = BTN_NONE;

   // Pin and button levels as the stimulus generator last left them. They can
   // run ahead of the prediction, since items are queued before they are sent.
   logic [1:0] gen_phase  = 2'd0;
   logic       gen_button = 1'b0;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(25, 90);
   endfunction

   // Works out the events of one accepted item and updates the predicted state.
   // A pin change moves the position by the table, clamps it, and then pays out
   // one event per full four counts, at most MAX_RESULTS of them; whatever is
   // left stays in the position. Only the enable that matches the sign of the
   // position counts, so a positive position with right turns disabled just
   // keeps growing even when left turns are enabled.
   task automatic decode_change(input enc_change_type chg);
      logic [3:0]    idx;
      logic [2:0]    kind;
      logic          armed;
      int            count;
      int            i;
      enc_event_type ev;
      armed = 1'b0;
      kind  = EV_RIGHT;
      count = 0;
      if (chg.mode) begin
         // Pin levels are ignored on a button change. A press always restarts
         // the click, even from shift; a release clicks only if never turned.
         if (chg.button_level) begin
            pred_button = BTN_CLICK;
         end else begin
            if (pred_button == BTN_CLICK && cfg_click_en) begin
               kind  = EV_CLICK;
               count = 1;
            end
            pred_button = BTN_NONE;
         end
      end else begin
         idx           = {chg.phase_b, chg.phase_a, pred_phase};
         pred_phase    = idx[3:2];
         pred_position = pred_position + QUARTER_MOVE[idx];
         if (pred_position > POS_LIMIT) pred_position = POS_LIMIT;
         if (pred_position < -POS_LIMIT) pred_position = -POS_LIMIT;
         if (pred_button == BTN_NONE) begin
            if (pred_position > 0 && cfg_right_en) begin
               armed = 1'b1;
               kind  = EV_RIGHT;
            end else if (pred_position < 0 && cfg_left_en) begin
               armed = 1'b1;
               kind  = EV_LEFT;
            end
         end else begin
            // Any pin change while the button is held turns it into a shift,
            // whether or not the position actually moved.
            if (pred_position > 0 && cfg_right_alt_en) begin
               armed = 1'b1;
               kind  = EV_RIGHT_ALT;
            end else if (pred_position < 0 && cfg_left_alt_en) begin
               armed = 1'b1;
               kind  = EV_LEFT_ALT;
            end
            pred_button = BTN_SHIFT;
         end
         if (armed) begin
            while (pred_position >= STEP_COUNTS && count < MAX_RESULTS) begin
               pred_position = pred_position - STEP_COUNTS;
               count++;
            end
            while (pred_position <= -STEP_COUNTS && count < MAX_RESULTS) begin
               pred_position = pred_position + STEP_COUNTS;
               count++;
            end
         end
      end
      for (i = 0; i < count; i++) begin
         ev.kind = kind;
         ev.last = (i == count - 1);
         expected_events.push_back(ev);
      end
   endtask

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // Pin change to the given levels (bit 0 pin A, bit 1 pin B). The button
   // level rides along with a random value since the decoder ignores it here.
   task automatic queue_pin(input logic [1:0] pins);
      enc_change_type chg;
      chg.mode         = 1'b0;
      chg.phase_a      = pins[0];
      chg.phase_b      = pins[1];
      chg.button_level = 1'($urandom_range(0, 1));
      pending_changes.push_back(chg);
      gen_phase = pins;
   endtask

   // Button change; the pin levels carry random values that must be ignored.
   task automatic queue_button(input logic level);
      enc_change_type chg;
      chg.mode         = 1'b1;
      chg.phase_a      = 1'($urandom_range(0, 1));
      chg.phase_b      = 1'($urandom_range(0, 1));
      chg.button_level = level;
      pending_changes.push_back(chg);
      gen_button = level;
   endtask

   // Random turning with the button now and then. Most pin changes are legal
   // single steps in a direction biased by pct_up; some skip a phase, and only
   // when the skip goes the same way, so a strong bias drives the position into
   // its clamp. A few pin changes repeat the phase or jump anywhere.
   task automatic queue_turns(input int count, input int pct_up, input int pct_skip,
                              input int pct_button);
      int         n;
      int         r;
      logic       up;
      logic [1:0] nxt;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < pct_button) begin
            // Usually a proper press or release, sometimes a repeated one.
            if ($urandom_range(0, 3) != 0) queue_button(!gen_button);
            else queue_button(1'($urandom_range(0, 1)));
         end else begin
            up = ($urandom_range(0, 99) < pct_up);
            if (r < pct_button + 3) begin
               nxt = 2'($urandom_range(0, 3));
            end else if (r < pct_button + 6) begin
               nxt = gen_phase;
            end else if ($urandom_range(0, 99) < pct_skip
                         && up == (gen_phase == 2'd0 || gen_phase == 2'd3)) begin
               nxt = gen_phase ^ 2'd3;
            end else begin
               nxt = up ? PHASE_UP[gen_phase] : PHASE_DOWN[gen_phase];
            end
            queue_pin(nxt);
         end
      end
   endtask

   // APB write: setup cycle, then access cycle until pready. The register takes
   // the value at the access edge, and our copy of the settings follows it.
   task automatic write_register(input logic [2:0] index, input logic [1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {{(CSR_DATA_BITS - 2){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         REG_RIGHT_ENABLE:     cfg_right_en = value[0];
         REG_LEFT_ENABLE:      cfg_left_en = value[0];
         REG_RIGHT_ALT_ENABLE: cfg_right_alt_en = value[0];
         REG_LEFT_ALT_ENABLE:  cfg_left_alt_en = value[0];
         REG_CLICK_ENABLE:     cfg_click_en = value[0];
         REG_INITIAL_PHASE: begin
            // Writing the start phase also reloads the live phase.
            pred_phase = value;
            gen_phase  = value;
         end
         default: ;
      endcase
   endtask

   task automatic configure(input logic right_en, input logic left_en,
                            input logic right_alt_en, input logic left_alt_en,
                            input logic click_en, input logic [1:0] start_phase);
      write_register(REG_RIGHT_ENABLE, {1'b0, right_en});
      write_register(REG_LEFT_ENABLE, {1'b0, left_en});
      write_register(REG_RIGHT_ALT_ENABLE, {1'b0, right_alt_en});
      write_register(REG_LEFT_ALT_ENABLE, {1'b0, left_alt_en});
      write_register(REG_CLICK_ENABLE, {1'b0, click_en});
      write_register(REG_INITIAL_PHASE, start_phase);
   endtask

   // Wait until every queued item is in and every owed event is out, then give
   // an item that emits nothing time to leave the sequencer.
   task automatic wait_idle();
      while (pending_changes.size() != 0 || offered_changes != accepted_changes
             || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input driver. A new item goes out only once the previous one has been
   // taken; with no gap drawn, valid simply stays high for the next item.
   always @(negedge clock) begin : change_driver
      enc_change_type chg;
      int             tx_gap;
      int             tx_burst;
      if (reset) begin
         req_chan.valid <= 1'b0;
         tx_gap   = 0;
         tx_burst = 0;
      end else if (!req_chan.valid || offered_changes == accepted_changes) begin
         if (tx_gap != 0) begin
            tx_gap = tx_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_changes.size() != 0) begin
            chg = pending_changes.pop_front();
            req_chan.mode         <= chg.mode;
            req_chan.phase_a      <= chg.phase_a;
            req_chan.phase_b      <= chg.phase_b;
            req_chan.button_level <= chg.button_level;
            req_chan.valid        <= 1'b1;
            offered_changes = offered_changes + 1;
            // Occasionally a run of items goes back to back.
            if (tx_burst != 0) begin
               tx_burst = tx_burst - 1;
               tx_gap   = 0;
            end else if ($urandom_range(0, 99) < 5) begin
               tx_burst = 25;
               tx_gap   = 0;
            end else begin
               tx_gap = idle_length();
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Event receiver. Random stalls with stretches of full speed, plus two long
   // hold-offs during which the sender keeps offering, so the block backs up
   // and stops taking items.
   always @(negedge clock) begin : event_receiver
      int stall;
      int free_run;
      int long_hold;
      int last_mark;
      int r;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall     = 0;
         free_run  = 0;
         long_hold = 0;
         last_mark = -1;
      end else begin
         if ((accepted_changes == HOLD_AT_FIRST || accepted_changes == HOLD_AT_LATER)
             && last_mark != accepted_changes) begin
            last_mark = accepted_changes;
            long_hold = LONG_HOLD;
         end
         if (long_hold != 0) begin
            long_hold = long_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall != 0) begin
            stall = stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (free_run != 0) begin
            free_run = free_run - 1;
            rsp_chan.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) free_run = 80;
            else if (r < 25) stall = idle_length();
            rsp_chan.ready <= (stall == 0);
            if (stall != 0) stall = stall - 1;
         end
      end
   end

   // Monitor. Events are checked before the item taken at the same edge is
   // predicted; an event can never belong to an item accepted at that edge.
   always @(posedge clock) begin : stream_monitor
      enc_event_type  got;
      enc_event_type  want;
      enc_change_type chg;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.event_kind;
            got.last = rsp_chan.is_last;
            if (expected_events.size() == 0) begin
               flag_error($sformatf("unexpected event: kind %0d last %0b",
                                    got.kind, got.last));
            end else begin
               want = expected_events.pop_front();
               if (got.kind !== want.kind || got.last !== want.last)
                  flag_error($sformatf(
                     "event mismatch: expected kind %0d last %0b, got kind %0d last %0b",
                     want.kind, want.last, got.kind, got.last));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            chg.mode         = req_chan.mode;
            chg.phase_a      = req_chan.phase_a;
            chg.phase_b      = req_chan.phase_b;
            chg.button_level = req_chan.button_level;
            decode_change(chg);
            accepted_changes <= accepted_changes + 1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_chan.valid        = 1'b0;
      req_chan.mode         = 1'b0;
      req_chan.phase_a      = 1'b0;
      req_chan.phase_b      = 1'b0;
      req_chan.button_level = 1'b0;
      rsp_chan.ready        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk with every handler enabled, starting from phase zero.
      configure(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0);
      // Two skipped phases make one full step to the right.
      queue_pin(2'd3);
      queue_pin(2'd0);
      // Same levels again: no movement.
      queue_pin(2'd0);
      // Press and release without turning gives a click; a second release
      // without a press gives nothing.
      queue_button(1'b1);
      queue_button(1'b0);
      queue_button(1'b0);
      // Turning while held gives an alt event and makes the press a shift.
      queue_button(1'b1);
      queue_pin(2'd3);
      queue_pin(2'd0);
      // Pressing again restarts the click, but a pin report with no movement
      // still turns it into a shift, so the release is silent.
      queue_button(1'b1);
      queue_pin(2'd0);
      queue_button(1'b0);
      // Four single steps the other way: one left event.
      queue_pin(2'd1);
      queue_pin(2'd3);
      queue_pin(2'd2);
      queue_pin(2'd0);
      // The same while held: one left alt event, then a silent release.
      queue_button(1'b1);
      queue_pin(2'd1);
      queue_pin(2'd3);
      queue_pin(2'd2);
      queue_pin(2'd0);
      queue_button(1'b0);
      wait_idle();

      // Balanced turning with everything enabled.
      configure(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 2'd2);
      queue_turns(60, 50, 20, 12);
      wait_idle();

      // Right turns muted while turning mostly right: the position climbs into
      // its upper clamp and stays there, with the left handler never consulted.
      configure(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1);
      queue_turns(140, 95, 60, 5);
      wait_idle();

      // Right turns back on: the first pin change pays out the capped burst,
      // and the remainder drains on later steps.
      configure(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 2'd3);
      queue_turns(40, 50, 20, 15);
      wait_idle();

      // Everything off while turning mostly left, into the lower clamp.
      configure(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
      queue_turns(130, 5, 60, 5);
      wait_idle();

      // Left handlers back on to drain the negative position.
      configure(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 2'd3);
      queue_turns(40, 50, 20, 15);
      wait_idle();

      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- quadrature_encoder_with_button_unit.f -----
hdl/qenc_pkg.sv
hdl/qenc_channels.sv
hdl/qenc_csr.sv
hdl/qenc_alu.sv
hdl/qenc_ctrl.sv
hdl/quadrature_encoder_with_button_unit.sv
test/tb_quadrature_encoder_with_button_unit.sv
